[sv/ssp_pkg.sv]
package ssp_pkg;

    localparam int FRAC_BITS = 16;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 64;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef logic signed [31:0] sword_t;
    typedef logic [30:0]        creg_t;
    typedef logic [7:0]         cfg_idx_t;
    typedef logic [31:0]        cfg_data_t;

    localparam cfg_idx_t REG_MAX_FORCE   = 8'd0;
    localparam cfg_idx_t REG_MAX_SPEED   = 8'd1;
    localparam cfg_idx_t REG_REST_LENGTH = 8'd2;
    localparam cfg_idx_t REG_SPRING_K    = 8'd3;
    localparam cfg_idx_t REG_CENTRE_X    = 8'd4;
    localparam cfg_idx_t REG_CENTRE_Y    = 8'd5;

    localparam logic [63:0] REG_MASK64 = 64'h0000_0000_7FFF_FFFF;
    localparam logic signed [33:0] S34_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S34_MIN = -34'sd2147483648;

    function automatic creg_t reset_coord(input logic [63:0] whole);
        logic [63:0] v;
        v = whole << FRAC_BITS;
        return (v > REG_MASK64) ? creg_t'(REG_MASK64) : v[30:0];
    endfunction

    localparam creg_t CENTRE_X_RST = reset_coord(64'd512);
    localparam creg_t CENTRE_Y_RST = reset_coord(64'd384);

    typedef struct packed {
        creg_t max_force;
        creg_t max_speed;
        creg_t rest_length;
        creg_t spring_k;
        creg_t centre_x;
        creg_t centre_y;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } iter_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_sts_t;

    function automatic sword_t sat32(input logic signed [33:0] v);
        if (v > S34_MAX)
            return sword_t'(S34_MAX[31:0]);
        else if (v < S34_MIN)
            return sword_t'(S34_MIN[31:0]);
        else
            return v[31:0];
    endfunction

    function automatic sword_t add_sat(input sword_t a, input sword_t b);
        return sat32($signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b}));
    endfunction

    function automatic sword_t sub_sat(input sword_t a, input sword_t b);
        return sat32($signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b}));
    endfunction

    function automatic sword_t neg_sat(input sword_t a);
        return sub_sat(32'sd0, a);
    endfunction

    function automatic logic [31:0] abs32(input sword_t a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    // Apply a sign to an unsigned magnitude and clamp to the signed word range.
    function automatic sword_t sign_sat(input logic neg, input logic [63:0] q);
        if (!neg)
            return (q > 64'd2147483647) ? sword_t'(32'h7FFF_FFFF) : q[31:0];
        else
            return (q > 64'd2147483648) ? sword_t'(32'h8000_0000) : (~q[31:0] + 32'd1);
    endfunction

endpackage

[sv/ssp_target_if.sv]
interface ssp_target_if;
    logic           valid;
    logic           ready;
    ssp_pkg::sword_t target_x;
    ssp_pkg::sword_t target_y;
    ssp_pkg::sword_t target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink (input valid, input target_x, input target_y, input target_z,
                  output ready);
endinterface

[sv/ssp_result_if.sv]
interface ssp_result_if;
    logic           valid;
    logic           ready;
    ssp_pkg::sword_t pos_x;
    ssp_pkg::sword_t pos_y;
    ssp_pkg::sword_t pos_z;
    ssp_pkg::sword_t vel_x;
    ssp_pkg::sword_t vel_y;
    ssp_pkg::sword_t vel_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output vel_x, output vel_y, output vel_z, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input vel_x, input vel_y, input vel_z, output ready);
endinterface

[sv/ssp_cfg_if.sv]
interface ssp_cfg_if;
    logic                valid;
    logic                ready;
    ssp_pkg::cfg_idx_t  index;
    ssp_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/ssp_cfg_regs.sv]
module ssp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    ssp_cfg_if.sink       cfg,
    output ssp_pkg::cfg_t regs
);
    import ssp_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.max_force   <= '0;
            regs_reg.max_speed   <= '0;
            regs_reg.rest_length <= '0;
            regs_reg.spring_k    <= '0;
            regs_reg.centre_x    <= CENTRE_X_RST;
            regs_reg.centre_y    <= CENTRE_Y_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_FORCE:   regs_reg.max_force   <= cfg.data[30:0];
                REG_MAX_SPEED:   regs_reg.max_speed   <= cfg.data[30:0];
                REG_REST_LENGTH: regs_reg.rest_length <= cfg.data[30:0];
                REG_SPRING_K:    regs_reg.spring_k    <= cfg.data[30:0];
                REG_CENTRE_X:    regs_reg.centre_x    <= cfg.data[30:0];
                REG_CENTRE_Y:    regs_reg.centre_y    <= cfg.data[30:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

[sv/ssp_iter_unit.sv]
module ssp_iter_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  ssp_pkg::iter_cmd_t cmd,
    input  logic [63:0]        opa,
    input  logic [31:0]        divisor,
    output ssp_pkg::iter_sts_t sts,
    output logic [63:0]        res
);
    import ssp_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic             sqrt_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      acc_reg;
    logic [35:0]      rem_reg;
    logic [31:0]      root_reg;
    logic [31:0]      div_reg;

    logic [35:0] sq_rem;
    logic [35:0] sq_trial;
    logic        sq_ge;
    logic [35:0] dv_rem;
    logic [35:0] dv_sub;
    logic        dv_ge;

    // Root: two radicand bits per step. Quotient: one dividend bit per step.
    assign sq_rem   = {rem_reg[33:0], acc_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_rem >= sq_trial);
    assign dv_rem   = {rem_reg[34:0], acc_reg[63]};
    assign dv_sub   = {4'b0000, div_reg};
    assign dv_ge    = (dv_rem >= dv_sub);

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res      = sqrt_reg ? {32'd0, root_reg} : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= cmd.is_sqrt;
                cnt_reg  <= cmd.is_sqrt ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg  <= opa;
            rem_reg  <= '0;
            root_reg <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                rem_reg  <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
                root_reg <= {root_reg[30:0], sq_ge};
                acc_reg  <= {acc_reg[61:0], 2'b00};
            end
            else
            begin
                rem_reg <= dv_ge ? (dv_rem - dv_sub) : dv_rem;
                acc_reg <= {acc_reg[62:0], dv_ge};
            end
        end
    end

endmodule

[sv/spring_seek_particle_step.sv]
// The shared root/divide unit takes 32 steps per vector length and 64 steps per
// rescaled component; an item takes four lengths and up to four 3-component rescales.
// One item is in flight at a time; a new target is taken once the result is handed to
// the output register. Reset is asynchronous, active low: position (512, 384, 0),
// velocity zero, centre (512, 384), limits, rest length and stiffness zero.
module spring_seek_particle_step (
    input  logic          clk,
    input  logic          rst_n,
    ssp_target_if.sink    target,
    ssp_result_if.source  result,
    ssp_cfg_if.sink       cfg
);
    import ssp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQMUL  = 4'd1;
    localparam logic [3:0] S_SQACC  = 4'd2;
    localparam logic [3:0] S_SQGO   = 4'd3;
    localparam logic [3:0] S_SQW    = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_MAGMUL = 4'd6;
    localparam logic [3:0] S_MAGWR  = 4'd7;
    localparam logic [3:0] S_RSMUL  = 4'd8;
    localparam logic [3:0] S_DIVGO  = 4'd9;
    localparam logic [3:0] S_DIVW   = 4'd10;
    localparam logic [3:0] S_NEXT   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [1:0] P_SPRING = 2'd0;
    localparam logic [1:0] P_SEEK   = 2'd1;
    localparam logic [1:0] P_STEER  = 2'd2;
    localparam logic [1:0] P_VEL    = 2'd3;

    cfg_t      regs;
    iter_cmd_t cmd;
    iter_sts_t sts;
    logic [63:0] iter_res;

    logic [3:0] state_reg;
    logic [1:0] phase_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    sword_t     pos_reg [3];
    sword_t     vel_reg [3];

    sword_t      vec_reg [3];
    sword_t      spr_reg [3];
    sword_t      tgt_reg [3];
    logic [63:0] sum_reg;
    logic [31:0] len_reg;
    creg_t       mag_reg;
    logic        stretch_pos_reg;
    logic [63:0] mul_reg;
    sword_t      out_reg [6];

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic signed [33:0] stretch;
    logic [31:0]        stretch_abs;
    logic [63:0]        mag_shift;

    ssp_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign cmd.start   = (state_reg == S_SQGO) || (state_reg == S_DIVGO);
    assign cmd.is_sqrt = (state_reg == S_SQGO);

    ssp_iter_unit u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .opa     ((state_reg == S_SQGO) ? sum_reg : mul_reg),
        .divisor (len_reg),
        .sts     (sts),
        .res     (iter_res)
    );

    assign stretch     = $signed({2'b00, len_reg}) - $signed({3'b000, regs.rest_length});
    assign stretch_abs = stretch[33] ? 32'(-stretch) : stretch[31:0];
    assign mag_shift   = mul_reg >> FRAC_BITS;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQMUL:
            begin
                mul_a = abs32(vec_reg[idx_reg]);
                mul_b = abs32(vec_reg[idx_reg]);
            end
            S_MAGMUL:
            begin
                mul_a = stretch_abs;
                mul_b = {1'b0, regs.spring_k};
            end
            S_RSMUL:
            begin
                mul_a = abs32(vec_reg[idx_reg]);
                mul_b = {1'b0, mag_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign target.ready = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.pos_x = out_reg[0];
    assign result.pos_y = out_reg[1];
    assign result.pos_z = out_reg[2];
    assign result.vel_x = out_reg[3];
    assign result.vel_y = out_reg[4];
    assign result.vel_z = out_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_SPRING;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            pos_reg[0]    <= {1'b0, CENTRE_X_RST};
            pos_reg[1]    <= {1'b0, CENTRE_Y_RST};
            pos_reg[2]    <= '0;
            vel_reg[0]    <= '0;
            vel_reg[1]    <= '0;
            vel_reg[2]    <= '0;
        end
        else
        begin
            // The output stage reloads in the same cycle that it is drained.
            if (result.ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (target.valid)
                    begin
                        state_reg <= S_SQMUL;
                        phase_reg <= P_SPRING;
                        idx_reg   <= '0;
                    end
                S_SQMUL:
                    state_reg <= S_SQACC;
                S_SQACC:
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SQGO;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SQMUL;
                    end
                S_SQGO:
                    state_reg <= S_SQW;
                S_SQW:
                    if (sts.done)
                        state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    idx_reg <= '0;
                    unique case (phase_reg)
                        P_SPRING: state_reg <= (len_reg == '0) ? S_NEXT : S_MAGMUL;
                        P_SEEK:   state_reg <= (len_reg == '0) ? S_NEXT : S_RSMUL;
                        P_STEER:
                            state_reg <= (len_reg > {1'b0, regs.max_force}) ? S_RSMUL : S_NEXT;
                        P_VEL:
                            state_reg <= (len_reg > {1'b0, regs.max_speed}) ? S_RSMUL : S_NEXT;
                        default:  state_reg <= S_NEXT;
                    endcase
                end
                S_MAGMUL:
                    state_reg <= S_MAGWR;
                S_MAGWR:
                    state_reg <= S_RSMUL;
                S_RSMUL:
                    state_reg <= S_DIVGO;
                S_DIVGO:
                    state_reg <= S_DIVW;
                S_DIVW:
                    if (sts.done)
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_RSMUL;
                        end
                    end
                S_NEXT:
                begin
                    unique case (phase_reg)
                        P_SPRING:
                        begin
                            phase_reg <= P_SEEK;
                            state_reg <= S_SQMUL;
                        end
                        P_SEEK:
                        begin
                            phase_reg <= P_STEER;
                            state_reg <= S_SQMUL;
                        end
                        P_STEER:
                        begin
                            phase_reg <= P_VEL;
                            state_reg <= S_SQMUL;
                        end
                        default:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                vel_reg[i] <= vec_reg[i];
                                pos_reg[i] <= add_sat(pos_reg[i], vec_reg[i]);
                            end
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_OUT:
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
                if (target.valid)
                begin
                    tgt_reg[0] <= target.target_x;
                    tgt_reg[1] <= target.target_y;
                    tgt_reg[2] <= target.target_z;
                    vec_reg[0] <= sub_sat(pos_reg[0], {1'b0, regs.centre_x});
                    vec_reg[1] <= sub_sat(pos_reg[1], {1'b0, regs.centre_y});
                    vec_reg[2] <= pos_reg[2];
                end
            S_SQACC:
                sum_reg <= (idx_reg == 2'd0) ? mul_reg : (sum_reg + mul_reg);
            S_SQW:
                if (sts.done)
                    len_reg <= iter_res[31:0];
            S_DECIDE:
                case (phase_reg)
                    P_SPRING:
                        if (len_reg == '0)
                            for (int i = 0; i < 3; i++)
                                vec_reg[i] <= '0;
                    P_SEEK:
                    begin
                        mag_reg <= regs.max_speed;
                        if (len_reg == '0)
                            for (int i = 0; i < 3; i++)
                                vec_reg[i] <= '0;
                    end
                    P_STEER:
                        mag_reg <= regs.max_force;
                    default:
                        mag_reg <= regs.max_speed;
                endcase
            S_MAGMUL:
                stretch_pos_reg <= !stretch[33] && (stretch != '0);
            S_MAGWR:
                mag_reg <= (mag_shift > REG_MASK64) ? '1 : mag_shift[30:0];
            S_DIVW:
                if (sts.done)
                    vec_reg[idx_reg] <= sign_sat(vec_reg[idx_reg][31], iter_res);
            S_NEXT:
                case (phase_reg)
                    P_SPRING:
                        for (int i = 0; i < 3; i++)
                        begin
                            // A stretched spring pulls back toward the centre.
                            spr_reg[i] <= stretch_pos_reg ? neg_sat(vec_reg[i]) : vec_reg[i];
                            vec_reg[i] <= sub_sat(tgt_reg[i], pos_reg[i]);
                        end
                    P_SEEK:
                        for (int i = 0; i < 3; i++)
                            vec_reg[i] <= sub_sat(vec_reg[i], vel_reg[i]);
                    P_STEER:
                        for (int i = 0; i < 3; i++)
                            vec_reg[i] <= add_sat(vel_reg[i], add_sat(spr_reg[i], vec_reg[i]));
                    default:
                    begin
                    end
                endcase
            S_OUT:
                if (!out_valid_reg || result.ready)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        out_reg[i]     <= pos_reg[i];
                        out_reg[i + 3] <= vel_reg[i];
                    end
                end
            default:
            begin
            end
        endcase
    end

    a_unit_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQW || state_reg == S_DIVW) |-> (sts.busy || sts.done))
        else $error("waiting on the root/divide unit while it is idle");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVGO) |-> (len_reg != '0))
        else $error("rescale started with a zero length");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (target.valid && target.ready) |=> (state_reg != S_IDLE))
        else $error("accepted target beat did not start a step");

endmodule
